// ===== rtl/lpfd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpfd_pkg
// Shared types and constants of the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package lpfd_pkg;

   localparam int unsigned ByteW    = 8;
   localparam int unsigned FieldW   = 16;
   localparam int unsigned KindW    = 3;
   localparam int unsigned RspDataW = ByteW + FieldW;

   // Result kinds as they appear on the result channel's tuser.
   typedef enum logic [KindW-1:0] {
      KIND_PAYLOAD = 3'd0,
      KIND_EMPTY   = 3'd1,
      KIND_BAD_ID  = 3'd2,
      KIND_BAD_LEN = 3'd3,
      KIND_FAULT   = 3'd4
   } kind_type;

   localparam logic [FieldW-1:0] SizeLimitReset = 16'd1024;

endpackage

`default_nettype wire

// ===== rtl/length_prefixed_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer
// Splits a byte stream into frames with a big-endian id and length header,
// emits the payload bytes tagged with the frame id, and reports errors.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata                         | tuser       | tlast
//  req_     | in        | data_byte                     | link_fault  | -
//  rsp_     | out       | payload_byte, message_id      | kind        | last
//  csr_     | in        | size_limit (write only)       | -           | -
//
//  A request is accepted every cycle while the result path moves; each byte
//  passes the input register, and any result it gives the result register.
//  The frame state (header count, bytes left, id) updates as each byte leaves
//  the input register, so sustained throughput is one byte per clock when not stalled.
//  A stalled result holds the input register; reset is synchronous and
//  returns the block to the header state with the error halt cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_frame_deframer #(
   parameter int unsigned ID_BYTES     = 2,
   parameter int unsigned LENGTH_BYTES = 2
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // Request channel.
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [lpfd_pkg::ByteW-1:0]            req_tdata,  // [7:0] data_byte
   input  wire logic                                  req_tuser,  // [0] link_fault
   // Result channel.
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic [lpfd_pkg::RspDataW-1:0]              rsp_tdata,  // [7:0] payload_byte,
                                                                  // [23:8] message_id
   output logic [lpfd_pkg::KindW-1:0]                 rsp_tuser,  // [2:0] kind
   output logic                                       rsp_tlast,  // last
   // Configuration.
   input  wire logic                                  csr_wr_en,
   input  wire logic [lpfd_pkg::FieldW-1:0]           csr_wr_data // size_limit
);

   localparam int unsigned HdrBytes = ID_BYTES + LENGTH_BYTES;
   localparam int unsigned HdrCntW  = $clog2(HdrBytes);
   localparam int unsigned HdrW     = 8 * (HdrBytes - 1);
   localparam int unsigned FullW    = 8 * HdrBytes;
   localparam int unsigned LenW     = 8 * LENGTH_BYTES;
   localparam int unsigned IdW      = 8 * ID_BYTES;
   localparam logic [HdrCntW-1:0] HdrLast = HdrCntW'(HdrBytes - 1);

   logic [lpfd_pkg::FieldW-1:0] size_limit_ff;

   // Input register.
   logic                       in_valid_ff, in_valid_in;
   logic [lpfd_pkg::ByteW-1:0] in_byte_ff;
   logic                       in_fault_ff;

   // Frame state.
   logic                        in_payload_ff, in_payload_in;
   logic [HdrCntW-1:0]          hdr_cnt_ff, hdr_cnt_in;
   logic [HdrW-1:0]             hdr_bytes_ff, hdr_bytes_in;
   logic [lpfd_pkg::FieldW-1:0] cur_id_ff, cur_id_in;
   logic [lpfd_pkg::FieldW-1:0] bytes_left_ff, bytes_left_in;
   logic                        halted_ff, halted_in;

   // Result register.
   logic                        rsp_valid_ff, rsp_valid_in;
   lpfd_pkg::kind_type          rsp_kind_ff;
   logic [lpfd_pkg::ByteW-1:0]  rsp_byte_ff;
   logic [lpfd_pkg::FieldW-1:0] rsp_id_ff;
   logic                        rsp_last_ff;

   // Result of the item being processed this cycle.
   logic                        res_valid;
   lpfd_pkg::kind_type          res_kind;
   logic [lpfd_pkg::ByteW-1:0]  res_byte;
   logic [lpfd_pkg::FieldW-1:0] res_id;
   logic                        res_last;

   logic                        advance;
   logic [FullW-1:0]            hdr_full;
   logic [lpfd_pkg::FieldW-1:0] hdr_id;
   logic [lpfd_pkg::FieldW-1:0] hdr_len;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign hdr_full = {hdr_bytes_ff, in_byte_ff};
   assign hdr_len  = lpfd_pkg::FieldW'(hdr_full[LenW-1:0]);
   assign hdr_id   = lpfd_pkg::FieldW'(hdr_full[FullW-1 -: IdW]);

   always_comb begin
      in_payload_in = in_payload_ff;
      hdr_cnt_in    = hdr_cnt_ff;
      hdr_bytes_in  = hdr_bytes_ff;
      cur_id_in     = cur_id_ff;
      bytes_left_in = bytes_left_ff;
      halted_in     = halted_ff;
      res_valid     = 1'b0;
      res_kind      = lpfd_pkg::KIND_PAYLOAD;
      res_byte      = '0;
      res_id        = cur_id_ff;
      res_last      = 1'b0;

      if (advance && !halted_ff) begin
         if (in_fault_ff) begin
            halted_in = 1'b1;
            res_valid = 1'b1;
            res_kind  = lpfd_pkg::KIND_FAULT;
         end else if (in_payload_ff) begin
            res_valid     = 1'b1;
            res_byte      = in_byte_ff;
            res_last      = (bytes_left_ff <= lpfd_pkg::FieldW'(1));
            bytes_left_in = bytes_left_ff - lpfd_pkg::FieldW'(1);
            if (res_last) begin
               bytes_left_in = '0;
               in_payload_in = 1'b0;
               hdr_cnt_in    = '0;
               hdr_bytes_in  = '0;
            end
         end else if (hdr_cnt_ff != HdrLast) begin
            hdr_bytes_in = HdrW'({hdr_bytes_ff, in_byte_ff});
            hdr_cnt_in   = hdr_cnt_ff + HdrCntW'(1);
         end else begin
            // Header complete: the id is checked before the length.
            hdr_cnt_in   = '0;
            hdr_bytes_in = '0;
            if (hdr_id > size_limit_ff) begin
               halted_in = 1'b1;
               res_valid = 1'b1;
               res_kind  = lpfd_pkg::KIND_BAD_ID;
               res_id    = hdr_id;
            end else if (hdr_len > size_limit_ff) begin
               halted_in = 1'b1;
               res_valid = 1'b1;
               res_kind  = lpfd_pkg::KIND_BAD_LEN;
               res_id    = hdr_id;
            end else begin
               cur_id_in = hdr_id;
               if (hdr_len == '0) begin
                  res_valid = 1'b1;
                  res_kind  = lpfd_pkg::KIND_EMPTY;
                  res_id    = hdr_id;
                  res_last  = 1'b1;
               end else begin
                  bytes_left_in = hdr_len;
                  in_payload_in = 1'b1;
               end
            end
         end
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (advance && res_valid) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_limit_ff <= lpfd_pkg::SizeLimitReset;
         in_valid_ff   <= 1'b0;
         in_payload_ff <= 1'b0;
         hdr_cnt_ff    <= '0;
         hdr_bytes_ff  <= '0;
         cur_id_ff     <= '0;
         bytes_left_ff <= '0;
         halted_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            size_limit_ff <= csr_wr_data;
         end
         in_valid_ff   <= in_valid_in;
         in_payload_ff <= in_payload_in;
         hdr_cnt_ff    <= hdr_cnt_in;
         hdr_bytes_ff  <= hdr_bytes_in;
         cur_id_ff     <= cur_id_in;
         bytes_left_ff <= bytes_left_in;
         halted_ff     <= halted_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff  <= req_tdata;
         in_fault_ff <= req_tuser;
      end
      if (advance && res_valid) begin
         rsp_kind_ff <= res_kind;
         rsp_byte_ff <= res_byte;
         rsp_id_ff   <= res_id;
         rsp_last_ff <= res_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_id_ff, rsp_byte_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// ===== rtl/lpfd_checker.sv =====
// ----------------------------------------------------------------------------
// lpfd_checker
// Port-level checks of the frame deframer's result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfd_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [lpfd_pkg::RspDataW-1:0]    rsp_tdata,
   input wire logic [lpfd_pkg::KindW-1:0]       rsp_tuser,
   input wire logic                             rsp_tlast
);

   logic is_error;

   assign is_error = (rsp_tuser == lpfd_pkg::KIND_BAD_ID) ||
                     (rsp_tuser == lpfd_pkg::KIND_BAD_LEN) ||
                     (rsp_tuser == lpfd_pkg::KIND_FAULT);

   // A stalled result keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // Only payload bytes and empty messages can close a frame.
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |->
         (rsp_tuser == lpfd_pkg::KIND_PAYLOAD) || (rsp_tuser == lpfd_pkg::KIND_EMPTY))
      else $error("tlast on a result that does not end a frame");

   // An empty message always closes its frame and carries no byte.
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == lpfd_pkg::KIND_EMPTY) |->
         rsp_tlast && (rsp_tdata[lpfd_pkg::ByteW-1:0] == '0))
      else $error("malformed empty message result");

   // Errors carry no byte and do not mark a frame end.
   a_error_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && is_error |-> !rsp_tlast && (rsp_tdata[lpfd_pkg::ByteW-1:0] == '0))
      else $error("malformed error result");

   // The block halts after an error, so nothing follows the error result.
   a_halt: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && is_error |=> !rsp_tvalid)
      else $error("result produced after an error");

endmodule

bind length_prefixed_frame_deframer lpfd_checker u_lpfd_checker (.*);

`default_nettype wire
